@@ rtl/core/pinhole_point_projection_unit_assert.svh @@
// Assertion macros shared by the pinhole point projection RTL.
`ifndef PINHOLE_POINT_PROJECTION_UNIT_ASSERT_SVH
`define PINHOLE_POINT_PROJECTION_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define PPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define PPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define PPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/ppp_pkg.sv @@
// Shared widths, register indexes and word types of the projection pipeline.
`default_nettype none

package ppp_pkg;

    localparam int DIM_BITS   = 13;
    localparam int PT_W       = 32;
    localparam int D_W        = PT_W + 1;
    localparam int AX_W       = 16;
    localparam int AXIS_W     = 3 * AX_W;
    localparam int PROD_W     = D_W + AX_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int FRAC_SHIFT = 14;
    localparam int C_W        = ACC_W - FRAC_SHIFT;
    localparam int F_W        = 24;
    localparam int DIMS_W     = 2 * DIM_BITS;
    localparam int CF_W       = C_W + F_W;
    localparam int DZ_W       = C_W + DIM_BITS;
    localparam int N_W        = 64;
    localparam int MAG_W      = N_W - 1;
    localparam int DEN_SHIFT  = 9;
    localparam int HALF_SHIFT = 8;
    localparam int DEN_W      = C_W - 1 + DEN_SHIFT;
    localparam int REM_W      = DEN_W + DIM_BITS;

    localparam int IN_TDATA_W  = 3 * PT_W;
    localparam int OUT_TDATA_W = ((2 * DIM_BITS + 7) / 8) * 8;

    localparam int CFG_NUM   = 8;
    localparam int CFG_IDX_W = $clog2(CFG_NUM);
    localparam int CFG_W     = AXIS_W;

    localparam logic [CFG_IDX_W-1:0] REG_AXIS_RIGHT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_DOWN    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_FORWARD = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_CAM_POS_X    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_CAM_POS_Y    = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_CAM_POS_Z    = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_PX     = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_DIMS   = CFG_IDX_W'(7);

    typedef struct packed {
        logic [2:0][AXIS_W-1:0] axis;
        logic [2:0][PT_W-1:0]   pos;
        logic [F_W-1:0]         focal;
        logic [DIMS_W-1:0]      dims;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        axis:  {AXIS_W'(48'h4000_0000_0000), AXIS_W'(48'h0000_4000_0000),
                AXIS_W'(48'h0000_0000_4000)},
        pos:   '0,
        focal: F_W'(128000),
        dims:  {DIM_BITS'(640), DIM_BITS'(480)}
    };

    typedef struct packed {
        logic signed [C_W-1:0] cx;
        logic signed [C_W-1:0] cy;
        logic signed [C_W-1:0] cz;
    } dot_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag_row;
        logic [MAG_W-1:0] mag_col;
        logic [DEN_W-1:0] den;
        logic             neg_row;
        logic             neg_col;
        logic             front;
    } num_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] q_row;
        logic [DIM_BITS-1:0] q_col;
        logic                ovf_row;
        logic                ovf_col;
        logic                neg_row;
        logic                neg_col;
        logic                front;
    } quo_t;

endpackage

`default_nettype wire

@@ rtl/core/ppp_dot.sv @@
// Camera-space transform: subtract camera position, dot with the three axes.
`default_nettype none

module ppp_dot (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire ppp_pkg::cfg_t                      cfg,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [2:0][ppp_pkg::PT_W-1:0]      in_point,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output ppp_pkg::dot_t                           out_dot
);

    localparam int STAGES = 3;

    logic [STAGES-1:0] v_reg;
    logic [STAGES:0]   en;

    logic signed [ppp_pkg::D_W-1:0]    d_next    [3];
    logic signed [ppp_pkg::D_W-1:0]    d_reg     [3];
    logic signed [ppp_pkg::PROD_W-1:0] prod_next [3][3];
    logic signed [ppp_pkg::PROD_W-1:0] prod_reg  [3][3];
    logic signed [ppp_pkg::ACC_W-1:0]  acc       [3];
    logic signed [ppp_pkg::C_W-1:0]    c_next    [3];
    logic signed [ppp_pkg::C_W-1:0]    c_reg     [3];

    always_comb
    begin
        en[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            en[k] = ~v_reg[k] | en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[STAGES-1];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d_next[k] = ppp_pkg::D_W'($signed(in_point[k]))
                      - ppp_pkg::D_W'($signed(cfg.pos[k]));
        end
        for (int a = 0; a < 3; a++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_next[a][k] = ppp_pkg::PROD_W'(d_reg[k])
                    * ppp_pkg::PROD_W'($signed(cfg.axis[a][ppp_pkg::AX_W*k +: ppp_pkg::AX_W]));
            end
            acc[a] = ppp_pkg::ACC_W'(prod_reg[a][0]) + ppp_pkg::ACC_W'(prod_reg[a][1])
                   + ppp_pkg::ACC_W'(prod_reg[a][2]);
            c_next[a] = acc[a][ppp_pkg::ACC_W-1:ppp_pkg::FRAC_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d_reg <= d_next;
        end
        if (en[1])
        begin
            prod_reg <= prod_next;
        end
        if (en[2])
        begin
            c_reg <= c_next;
        end
    end

    assign out_dot.cx = c_reg[0];
    assign out_dot.cy = c_reg[1];
    assign out_dot.cz = c_reg[2];

endmodule

`default_nettype wire

@@ rtl/core/ppp_numer.sv @@
// Numerator and denominator setup for the rounded perspective divide.
`default_nettype none

module ppp_numer (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ppp_pkg::cfg_t  cfg,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire ppp_pkg::dot_t  in_dot,
    output logic                out_valid,
    input  wire logic           out_ready,
    output ppp_pkg::num_t       out_num
);

    localparam int STAGES = 3;

    logic [STAGES-1:0] v_reg;
    logic [STAGES:0]   en;

    logic [ppp_pkg::DIM_BITS-1:0] h;
    logic [ppp_pkg::DIM_BITS-1:0] w;

    logic                           front0_reg;
    logic signed [ppp_pkg::CF_W-1:0] cfr_reg;
    logic signed [ppp_pkg::CF_W-1:0] cfc_reg;
    logic signed [ppp_pkg::DZ_W-1:0] hz_reg;
    logic signed [ppp_pkg::DZ_W-1:0] wz_reg;
    logic signed [ppp_pkg::C_W-1:0]  z0_reg;

    logic                            front1_reg;
    logic signed [ppp_pkg::N_W-1:0]  nr_reg;
    logic signed [ppp_pkg::N_W-1:0]  nc_reg;
    logic signed [ppp_pkg::C_W-1:0]  z1_reg;

    logic [ppp_pkg::N_W-1:0] z256;
    logic [ppp_pkg::N_W-1:0] mr_full;
    logic [ppp_pkg::N_W-1:0] mc_full;
    ppp_pkg::num_t           num_next;
    ppp_pkg::num_t           num_reg;

    assign h = cfg.dims[ppp_pkg::DIM_BITS-1:0];
    assign w = cfg.dims[ppp_pkg::DIMS_W-1:ppp_pkg::DIM_BITS];

    always_comb
    begin
        en[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            en[k] = ~v_reg[k] | en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[STAGES-1];

    always_comb
    begin
        z256 = ppp_pkg::N_W'({z1_reg[ppp_pkg::C_W-2:0], ppp_pkg::HALF_SHIFT'(0)});
        mr_full = nr_reg[ppp_pkg::N_W-1] ? (z256 - ppp_pkg::N_W'(nr_reg))
                                         : (ppp_pkg::N_W'(nr_reg) + z256);
        mc_full = nc_reg[ppp_pkg::N_W-1] ? (z256 - ppp_pkg::N_W'(nc_reg))
                                         : (ppp_pkg::N_W'(nc_reg) + z256);
        num_next.front = front1_reg;
        if (front1_reg)
        begin
            num_next.mag_row = mr_full[ppp_pkg::MAG_W-1:0];
            num_next.mag_col = mc_full[ppp_pkg::MAG_W-1:0];
            num_next.neg_row = nr_reg[ppp_pkg::N_W-1];
            num_next.neg_col = nc_reg[ppp_pkg::N_W-1];
            num_next.den     = {z1_reg[ppp_pkg::C_W-2:0], ppp_pkg::DEN_SHIFT'(0)};
        end
        else
        begin
            num_next.mag_row = '0;
            num_next.mag_col = '0;
            num_next.neg_row = 1'b0;
            num_next.neg_col = 1'b0;
            num_next.den     = ppp_pkg::DEN_W'(1) << ppp_pkg::DEN_SHIFT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            front0_reg <= ~in_dot.cz[ppp_pkg::C_W-1] & (|in_dot.cz);
            cfr_reg    <= ppp_pkg::CF_W'(in_dot.cy) * ppp_pkg::CF_W'($signed({1'b0, cfg.focal}));
            cfc_reg    <= ppp_pkg::CF_W'(in_dot.cx) * ppp_pkg::CF_W'($signed({1'b0, cfg.focal}));
            hz_reg     <= ppp_pkg::DZ_W'(in_dot.cz) * ppp_pkg::DZ_W'($signed({1'b0, h}));
            wz_reg     <= ppp_pkg::DZ_W'(in_dot.cz) * ppp_pkg::DZ_W'($signed({1'b0, w}));
            z0_reg     <= in_dot.cz;
        end
        if (en[1])
        begin
            front1_reg <= front0_reg;
            nr_reg     <= (ppp_pkg::N_W'(cfr_reg) <<< 1)
                        + (ppp_pkg::N_W'(hz_reg) <<< ppp_pkg::HALF_SHIFT);
            nc_reg     <= (ppp_pkg::N_W'(cfc_reg) <<< 1)
                        + (ppp_pkg::N_W'(wz_reg) <<< ppp_pkg::HALF_SHIFT);
            z1_reg     <= z0_reg;
        end
        if (en[2])
        begin
            num_reg <= num_next;
        end
    end

    assign out_num = num_reg;

endmodule

`default_nettype wire

@@ rtl/core/ppp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, row and column lanes.
`default_nettype none
`include "pinhole_point_projection_unit_assert.svh"

module ppp_div (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire ppp_pkg::num_t  in_num,
    output logic                out_valid,
    input  wire logic           out_ready,
    output ppp_pkg::quo_t       out_quo
);

    localparam int STAGES  = ppp_pkg::DIM_BITS + 1;
    localparam int TRIAL_W = ppp_pkg::REM_W + 1;

    typedef struct packed {
        logic [ppp_pkg::REM_W-1:0]    rem;
        logic [ppp_pkg::DIM_BITS-1:0] q;
        logic                         ovf;
        logic                         neg;
    } lane_t;

    typedef struct packed {
        lane_t                     row;
        lane_t                     col;
        logic [ppp_pkg::DEN_W-1:0] den;
        logic                      front;
    } stage_t;

    function automatic lane_t lane_init(logic [ppp_pkg::MAG_W-1:0] mag,
                                        logic [ppp_pkg::DEN_W-1:0] den, logic neg);
        lane_t l;
        l.ovf = (mag >> ppp_pkg::DIM_BITS) >= ppp_pkg::MAG_W'(den);
        l.rem = l.ovf ? '0 : mag[ppp_pkg::REM_W-1:0];
        l.q   = '0;
        l.neg = neg;
        return l;
    endfunction

    function automatic lane_t div_step(lane_t l, logic [ppp_pkg::DEN_W-1:0] den, int b);
        logic [TRIAL_W-1:0] trial;
        lane_t              r;
        r     = l;
        trial = {1'b0, l.rem} - (TRIAL_W'(den) << b);
        if (!trial[TRIAL_W-1])
        begin
            r.rem = trial[ppp_pkg::REM_W-1:0];
            r.q   = l.q | (ppp_pkg::DIM_BITS'(1) << b);
        end
        return r;
    endfunction

    logic [STAGES-1:0] v_reg;
    logic [STAGES:0]   en;
    stage_t            stage_next [STAGES];
    stage_t            stage_reg  [STAGES];

    always_comb
    begin
        en[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            en[k] = ~v_reg[k] | en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[STAGES-1];

    always_comb
    begin
        stage_next[0].row   = lane_init(in_num.mag_row, in_num.den, in_num.neg_row);
        stage_next[0].col   = lane_init(in_num.mag_col, in_num.den, in_num.neg_col);
        stage_next[0].den   = in_num.den;
        stage_next[0].front = in_num.front;
        for (int k = 1; k < STAGES; k++)
        begin
            stage_next[k]     = stage_reg[k-1];
            stage_next[k].row = div_step(stage_reg[k-1].row, stage_reg[k-1].den,
                                         STAGES - 1 - k);
            stage_next[k].col = div_step(stage_reg[k-1].col, stage_reg[k-1].den,
                                         STAGES - 1 - k);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (en[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign out_quo.q_row   = stage_reg[STAGES-1].row.q;
    assign out_quo.q_col   = stage_reg[STAGES-1].col.q;
    assign out_quo.ovf_row = stage_reg[STAGES-1].row.ovf;
    assign out_quo.ovf_col = stage_reg[STAGES-1].col.ovf;
    assign out_quo.neg_row = stage_reg[STAGES-1].row.neg;
    assign out_quo.neg_col = stage_reg[STAGES-1].col.neg;
    assign out_quo.front   = stage_reg[STAGES-1].front;

    `PPP_ASSERT_IMP(a_rem_below_den, clk, rst_n, v_reg[STAGES-1],
        stage_reg[STAGES-1].row.rem < ppp_pkg::REM_W'(stage_reg[STAGES-1].den) &&
        stage_reg[STAGES-1].col.rem < ppp_pkg::REM_W'(stage_reg[STAGES-1].den))
    `PPP_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, !in_ready, out_valid && !out_ready)
    `PPP_ASSERT_NEXT(a_take_enters_pipe, clk, rst_n, in_valid && in_ready, v_reg[0])

endmodule

`default_nettype wire

@@ rtl/core/pinhole_point_projection_unit.sv @@
// Pinhole point projection top level: takes one signed Q16.16 world point per
// word and returns its image row, column and an inside flag. The point is moved
// to camera space (three dot products with the configured Q1.14 axes), divided by
// depth, scaled by the focal length, offset by half the image size and rounded
// half away from zero; points at or behind the camera, or off the image, give
// row and column zero with the flag low. One point is taken every cycle. The
// divider resolves one quotient bit per stage. Stalls on the output fill the
// pipeline's empty slots before input is held. Registers are to be written by
// the user only while the pipeline holds no points; the block does not enforce
// this.
`default_nettype none
`include "pinhole_point_projection_unit_assert.svh"

module pinhole_point_projection_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [ppp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [ppp_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // point_x [31:0], point_y [63:32], point_z [95:64]
    input  wire logic [ppp_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // pixel_row [DIM_BITS-1:0], pixel_col [2*DIM_BITS-1:DIM_BITS], zero pad above
    output logic [ppp_pkg::OUT_TDATA_W-1:0]          m_tdata,
    // inside_res [0]
    output logic                                     m_tuser
);

    ppp_pkg::cfg_t cfg_reg;

    logic                               dot_valid;
    logic                               dot_ready;
    ppp_pkg::dot_t                      dot_word;
    logic                               num_valid;
    logic                               num_ready;
    ppp_pkg::num_t                      num_word;
    logic                               quo_valid;
    logic                               quo_ready;
    ppp_pkg::quo_t                      quo_word;
    logic [2:0][ppp_pkg::PT_W-1:0]      point;

    logic [ppp_pkg::DIM_BITS-1:0] h;
    logic [ppp_pkg::DIM_BITS-1:0] w;
    logic                         row_ok;
    logic                         col_ok;
    logic                         inside_next;

    logic                         m_valid_reg;
    logic [ppp_pkg::DIM_BITS-1:0] row_reg;
    logic [ppp_pkg::DIM_BITS-1:0] col_reg;
    logic                         inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= ppp_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ppp_pkg::REG_AXIS_RIGHT:   cfg_reg.axis[0] <= cfg_data;
                ppp_pkg::REG_AXIS_DOWN:    cfg_reg.axis[1] <= cfg_data;
                ppp_pkg::REG_AXIS_FORWARD: cfg_reg.axis[2] <= cfg_data;
                ppp_pkg::REG_CAM_POS_X:    cfg_reg.pos[0]  <= cfg_data[ppp_pkg::PT_W-1:0];
                ppp_pkg::REG_CAM_POS_Y:    cfg_reg.pos[1]  <= cfg_data[ppp_pkg::PT_W-1:0];
                ppp_pkg::REG_CAM_POS_Z:    cfg_reg.pos[2]  <= cfg_data[ppp_pkg::PT_W-1:0];
                ppp_pkg::REG_FOCAL_PX:     cfg_reg.focal   <= cfg_data[ppp_pkg::F_W-1:0];
                ppp_pkg::REG_IMAGE_DIMS:   cfg_reg.dims    <= cfg_data[ppp_pkg::DIMS_W-1:0];
                default:                   cfg_reg         <= cfg_reg;
            endcase
        end
    end

    assign point = s_tdata;

    ppp_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_point  (point),
        .out_valid (dot_valid),
        .out_ready (dot_ready),
        .out_dot   (dot_word)
    );

    ppp_numer u_numer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (dot_valid),
        .in_ready  (dot_ready),
        .in_dot    (dot_word),
        .out_valid (num_valid),
        .out_ready (num_ready),
        .out_num   (num_word)
    );

    ppp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (num_valid),
        .in_ready  (num_ready),
        .in_num    (num_word),
        .out_valid (quo_valid),
        .out_ready (quo_ready),
        .out_quo   (quo_word)
    );

    assign h = cfg_reg.dims[ppp_pkg::DIM_BITS-1:0];
    assign w = cfg_reg.dims[ppp_pkg::DIMS_W-1:ppp_pkg::DIM_BITS];

    always_comb
    begin
        row_ok = ~quo_word.ovf_row & (~quo_word.neg_row | (quo_word.q_row == '0))
               & (quo_word.q_row < h);
        col_ok = ~quo_word.ovf_col & (~quo_word.neg_col | (quo_word.q_col == '0))
               & (quo_word.q_col < w);
        inside_next = quo_word.front & row_ok & col_ok;
    end

    assign quo_ready = ~m_valid_reg | m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (quo_ready)
        begin
            m_valid_reg <= quo_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (quo_ready)
        begin
            inside_reg <= inside_next;
            row_reg    <= inside_next ? quo_word.q_row : '0;
            col_reg    <= inside_next ? quo_word.q_col : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = ppp_pkg::OUT_TDATA_W'({col_reg, row_reg});
    assign m_tuser  = inside_reg;

    `PPP_ASSERT_IMP(a_hold_only_on_full_stall, clk, rst_n, !s_tready, m_tvalid && !m_tready)
    `PPP_ASSERT_IMP(a_outside_is_zero, clk, rst_n, m_tvalid && !m_tuser,
        row_reg == '0 && col_reg == '0)
    `PPP_ASSERT_IMP(a_new_word_from_divider, clk, rst_n, m_tvalid && !$past(m_tvalid),
        $past(quo_valid))

endmodule

`default_nettype wire
